### rtl/core/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg
// Shared types and constants of the window throughput meter.
// ----------------------------------------------------------------------------
package wtm_pkg;

    localparam int DATA_W = 32;
    localparam int TICK_W = 24;
    localparam int MUL_W  = 20;

    localparam logic [MUL_W-1:0]  US_PER_SECOND = 20'd1000000;
    localparam logic [DATA_W-1:0] RATE_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic capture;
        logic sub;
        logic add;
    } win_ctrl_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic mul_bit;
        logic div_step;
    } lane_ctrl_t;

endpackage

### rtl/core/wtm_ram.sv
// ----------------------------------------------------------------------------
// wtm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wtm_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/wtm_window.sv
// ----------------------------------------------------------------------------
// wtm_window
// Ring window of per-tick byte and time deltas with running sums.
// ----------------------------------------------------------------------------
module wtm_window #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  wtm_pkg::win_ctrl_t                               ctrl,
    input  logic [wtm_pkg::DATA_W-1:0]                       total_sent,
    input  logic [wtm_pkg::DATA_W-1:0]                       total_received,
    input  logic [wtm_pkg::TICK_W-1:0]                       tick_time_us,
    output logic [wtm_pkg::DATA_W+$clog2(WINDOW_DEPTH)-1:0]  sent_sum,
    output logic [wtm_pkg::DATA_W+$clog2(WINDOW_DEPTH)-1:0]  received_sum,
    output logic [wtm_pkg::TICK_W+$clog2(WINDOW_DEPTH)-1:0]  time_sum
);
    import wtm_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = DATA_W + SLOT_W;
    localparam int TSUM_W  = TICK_W + SLOT_W;
    localparam int ENTRY_W = 2 * DATA_W + TICK_W;

    logic [SLOT_W-1:0]       slot_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]       prev_sent_reg;
    logic [DATA_W-1:0]       prev_received_reg;
    logic [DATA_W-1:0]       in_sent_reg;
    logic [DATA_W-1:0]       in_received_reg;
    logic [TICK_W-1:0]       in_tick_reg;
    logic [SUM_W-1:0]        sent_sum_reg;
    logic [SUM_W-1:0]        received_sum_reg;
    logic [TSUM_W-1:0]       time_sum_reg;

    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] old_entry;
    logic [DATA_W-1:0]  ds;
    logic [DATA_W-1:0]  dr;

    assign ds = in_sent_reg - prev_sent_reg;
    assign dr = in_received_reg - prev_received_reg;
    assign old_entry = valid_reg[slot_reg] ? rdata : '0;

    wtm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.add),
        .waddr (slot_reg),
        .wdata ({ds, dr, in_tick_reg}),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg          <= '0;
            valid_reg         <= '0;
            prev_sent_reg     <= '0;
            prev_received_reg <= '0;
            sent_sum_reg      <= '0;
            received_sum_reg  <= '0;
            time_sum_reg      <= '0;
        end else begin
            if (ctrl.sub) begin
                sent_sum_reg     <= sent_sum_reg - SUM_W'(old_entry[ENTRY_W-1 -: DATA_W]);
                received_sum_reg <= received_sum_reg
                                    - SUM_W'(old_entry[TICK_W +: DATA_W]);
                time_sum_reg     <= time_sum_reg - TSUM_W'(old_entry[TICK_W-1:0]);
            end
            if (ctrl.add) begin
                sent_sum_reg       <= sent_sum_reg + SUM_W'(ds);
                received_sum_reg   <= received_sum_reg + SUM_W'(dr);
                time_sum_reg       <= time_sum_reg + TSUM_W'(in_tick_reg);
                valid_reg[slot_reg] <= 1'b1;
                slot_reg           <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                                      ? '0 : slot_reg + 1'b1;
                prev_sent_reg      <= in_sent_reg;
                prev_received_reg  <= in_received_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            in_sent_reg     <= total_sent;
            in_received_reg <= total_received;
            in_tick_reg     <= tick_time_us;
        end
    end

    assign sent_sum     = sent_sum_reg;
    assign received_sum = received_sum_reg;
    assign time_sum     = time_sum_reg;

endmodule

### rtl/core/wtm_rate_lane.sv
// ----------------------------------------------------------------------------
// wtm_rate_lane
// Bit-serial scale by one million followed by bit-serial restoring division.
// ----------------------------------------------------------------------------
module wtm_rate_lane #(
    parameter int SUM_W  = 36,
    parameter int TSUM_W = 28
) (
    input  logic                       aclk,
    input  wtm_pkg::lane_ctrl_t        ctrl,
    input  logic [SUM_W-1:0]           bytes,
    input  logic [TSUM_W-1:0]          divisor,
    output logic [wtm_pkg::DATA_W-1:0] rate
);
    import wtm_pkg::*;

    localparam int PROD_W = SUM_W + MUL_W;

    logic [SUM_W-1:0]  mcand_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TSUM_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic              ovf_reg;

    logic [TSUM_W:0]   trial;
    logic [TSUM_W:0]   diff;
    logic              qbit;

    assign trial = {rem_reg, prod_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            mcand_reg <= bytes;
            prod_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (ctrl.mul_step) begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0}
                        + (ctrl.mul_bit ? PROD_W'(mcand_reg) : '0);
        end else if (ctrl.div_step) begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            rem_reg  <= qbit ? diff[TSUM_W-1:0] : trial[TSUM_W-1:0];
            quo_reg  <= {quo_reg[DATA_W-2:0], qbit};
            ovf_reg  <= ovf_reg | quo_reg[DATA_W-1];
        end
    end

    assign rate = ovf_reg ? RATE_MAX : quo_reg;

endmodule

### rtl/core/window_throughput_meter.sv
// ----------------------------------------------------------------------------
// window_throughput_meter
// Sliding-window byte rate meter over the last WINDOW_DEPTH ticks.
// ----------------------------------------------------------------------------
// Each input beat carries the cumulative sent and received byte counters and
// the tick length in microseconds; each one yields exactly one result beat
// with both rates in bytes per second, saturated to 32 bits, and a flag that
// is set when the window holds no time at all. For each item the SUB, ADD
// and LOAD states update the window and load the lanes, the byte sums are
// then scaled by one million one bit at a time, one restoring division step
// per bit of the 56-bit product at the default depth follows, and the result
// finally moves to the output register, with both rates worked in parallel
// lanes. A result beat that is held off by the sink delays the move to the
// output register by the length of the stall. The block takes one item at a
// time and accepts the next one in the cycle after the result has moved to
// the output register.
module window_throughput_meter #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wtm_pkg::DATA_W-1:0] s_total_sent,
    input  logic [wtm_pkg::DATA_W-1:0] s_total_received,
    input  logic [wtm_pkg::TICK_W-1:0] s_tick_time_us,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wtm_pkg::DATA_W-1:0] m_sent_rate,
    output logic [wtm_pkg::DATA_W-1:0] m_received_rate,
    output logic                       m_no_time
);
    import wtm_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = DATA_W + SLOT_W;
    localparam int TSUM_W = TICK_W + SLOT_W;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam int CNT_W  = $clog2(PROD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MUL_W-1:0]  mul_sr_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] sent_rate_reg;
    logic [DATA_W-1:0] received_rate_reg;
    logic              no_time_reg;

    win_ctrl_t         win_ctrl;
    lane_ctrl_t        lane_ctrl;
    logic [SUM_W-1:0]  sent_sum;
    logic [SUM_W-1:0]  received_sum;
    logic [TSUM_W-1:0] time_sum;
    logic [DATA_W-1:0] sent_rate;
    logic [DATA_W-1:0] received_rate;
    logic              time_zero;
    logic              out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign time_zero = (time_sum == '0);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        win_ctrl.capture   = s_valid && s_ready;
        win_ctrl.sub       = (state_reg == ST_SUB);
        win_ctrl.add       = (state_reg == ST_ADD);
        lane_ctrl.load     = (state_reg == ST_LOAD);
        lane_ctrl.mul_step = (state_reg == ST_MUL);
        lane_ctrl.mul_bit  = mul_sr_reg[MUL_W-1];
        lane_ctrl.div_step = (state_reg == ST_DIV);
    end

    wtm_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (win_ctrl),
        .total_sent     (s_total_sent),
        .total_received (s_total_received),
        .tick_time_us   (s_tick_time_us),
        .sent_sum       (sent_sum),
        .received_sum   (received_sum),
        .time_sum       (time_sum)
    );

    wtm_rate_lane #(
        .SUM_W  (SUM_W),
        .TSUM_W (TSUM_W)
    ) u_sent_lane (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .bytes   (sent_sum),
        .divisor (time_sum),
        .rate    (sent_rate)
    );

    wtm_rate_lane #(
        .SUM_W  (SUM_W),
        .TSUM_W (TSUM_W)
    ) u_received_lane (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .bytes   (received_sum),
        .divisor (time_sum),
        .rate    (received_rate)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            mul_sr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    cnt_reg    <= '0;
                    mul_sr_reg <= US_PER_SECOND;
                    state_reg  <= ST_MUL;
                end
                ST_MUL: begin
                    mul_sr_reg <= {mul_sr_reg[MUL_W-2:0], 1'b0};
                    if (cnt_reg == CNT_W'(MUL_W - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        sent_rate_reg     <= time_zero ? RATE_MAX : sent_rate;
                        received_rate_reg <= time_zero ? RATE_MAX : received_rate;
                        no_time_reg       <= time_zero;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sent_rate     = sent_rate_reg;
    assign m_received_rate = received_rate_reg;
    assign m_no_time       = no_time_reg;

endmodule

### rtl/core/wtm_checker.sv
// ----------------------------------------------------------------------------
// wtm_checker
// Port-level checks of the window throughput meter, bound to the top level.
// ----------------------------------------------------------------------------
module wtm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [wtm_pkg::DATA_W-1:0] s_total_sent,
    input logic [wtm_pkg::DATA_W-1:0] s_total_received,
    input logic [wtm_pkg::TICK_W-1:0] s_tick_time_us,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [wtm_pkg::DATA_W-1:0] m_sent_rate,
    input logic [wtm_pkg::DATA_W-1:0] m_received_rate,
    input logic                       m_no_time
);
    import wtm_pkg::*;

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sent_rate)
            && $stable(m_received_rate) && $stable(m_no_time))
        else $error("result beat changed while stalled");

    // An empty time window always reports both rates saturated.
    a_no_time_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_time |-> m_sent_rate == RATE_MAX
            && m_received_rate == RATE_MAX)
        else $error("no_time set without saturated rates");

    // The meter works on one tick at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a tick is in progress");

    // Nothing arrives on the result side right after an input beat unless
    // it was already pending.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result beat appeared too early");

endmodule

bind window_throughput_meter wtm_checker u_wtm_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the window throughput meter.
// ----------------------------------------------------------------------------
// A short table of directed ticks covers reset, the counter extremes, a counter
// that runs backwards, fractional and saturated rates, and a window that is
// flushed to zero time. Random ticks follow. Most of them are counters that
// advance by plausible amounts, with bursts of zero-length ticks, maximum
// ticks and random jumps mixed in. Every accepted input beat updates a local
// model of the window, and each output beat is compared field by field with
// the oldest prediction. Backpressure and source gaps change by phase, and the
// sink also holds off once for a long stretch so that the meter stalls.
// ----------------------------------------------------------------------------
module tb;

    import wtm_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_TICKS = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 600;
    localparam int DIR_ROWS     = 10;

    typedef struct packed {
        logic [DATA_W-1:0] sent_rate;
        logic [DATA_W-1:0] received_rate;
        logic              no_time;
    } rate_t;

    typedef struct packed {
        bit    typed;
        rate_t want;
    } tick_note_t;

    typedef struct packed {
        logic [DATA_W-1:0] sent;
        logic [DATA_W-1:0] received;
        logic [TICK_W-1:0] tick;
        logic [4:0]        reps;
        tick_note_t        note;
    } tick_row_t;

    localparam tick_row_t DIRECTED [DIR_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 24'h00_0000, 5'd1,
          '{1'b1, '{RATE_MAX, RATE_MAX, 1'b1}}},
        '{32'd1000, 32'd2000, 24'd1000000, 5'd1,
          '{1'b1, '{32'd1000, 32'd2000, 1'b0}}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd1, '0},
        '{32'd5, 32'd3, 24'd1, 5'd1, '0},
        '{32'd5, 32'd3, 24'd0, 5'd1, '0},
        '{32'd7, 32'd11, 24'd3, 5'd1, '0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 24'd12345, 5'd1, '0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 24'd0, 5'd16,
          '{1'b1, '{RATE_MAX, RATE_MAX, 1'b1}}},
        '{32'h8000_0000, 32'hFFFF_FFFF, 24'd1, 5'd1,
          '{1'b1, '{RATE_MAX, 32'd0, 1'b0}}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 24'hFF_FFFF, 5'd1, '0}
    };

    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic [DATA_W-1:0] s_total_sent     = '0;
    logic [DATA_W-1:0] s_total_received = '0;
    logic [TICK_W-1:0] s_tick_time_us   = '0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    logic [DATA_W-1:0] m_sent_rate;
    logic [DATA_W-1:0] m_received_rate;
    logic              m_no_time;

    logic [DATA_W-1:0] slot_sent     [DEPTH];
    logic [DATA_W-1:0] slot_received [DEPTH];
    logic [TICK_W-1:0] slot_time     [DEPTH];
    logic [3:0]        next_slot;
    logic [DATA_W-1:0] last_sent;
    logic [DATA_W-1:0] last_received;
    logic [63:0]       sum_sent;
    logic [63:0]       sum_received;
    logic [63:0]       sum_time;

    tick_note_t tick_notes [$];
    rate_t      expected_rates [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 12;
    int recv_idle_pct = 55;
    int phase         = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    window_throughput_meter #(
        .WINDOW_DEPTH(DEPTH)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_total_sent    (s_total_sent),
        .s_total_received(s_total_received),
        .s_tick_time_us  (s_tick_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sent_rate     (m_sent_rate),
        .m_received_rate (m_received_rate),
        .m_no_time       (m_no_time)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] scaled_rate(input logic [63:0] bytes,
                                                      input logic [63:0] micros);
        logic [63:0] quotient;
        quotient = (bytes * 64'(US_PER_SECOND)) / micros;
        return (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[DATA_W-1:0];
    endfunction

    task automatic reset_window();
        for (int i = 0; i < DEPTH; i++) begin
            slot_sent[i]     = '0;
            slot_received[i] = '0;
            slot_time[i]     = '0;
        end
        next_slot     = '0;
        last_sent     = '0;
        last_received = '0;
        sum_sent      = '0;
        sum_received  = '0;
        sum_time      = '0;
    endtask

    task automatic advance_window(input logic [DATA_W-1:0] now_sent,
                                  input logic [DATA_W-1:0] now_received,
                                  input logic [TICK_W-1:0] tick,
                                  output rate_t            rates);
        logic [DATA_W-1:0] d_sent;
        logic [DATA_W-1:0] d_received;
        d_sent       = now_sent - last_sent;
        d_received   = now_received - last_received;
        sum_sent     = sum_sent - 64'(slot_sent[next_slot]) + 64'(d_sent);
        sum_received = sum_received - 64'(slot_received[next_slot]) + 64'(d_received);
        sum_time     = sum_time - 64'(slot_time[next_slot]) + 64'(tick);
        slot_sent[next_slot]     = d_sent;
        slot_received[next_slot] = d_received;
        slot_time[next_slot]     = tick;
        next_slot     = next_slot + 4'd1;
        last_sent     = now_sent;
        last_received = now_received;
        if (sum_time == 0) begin
            rates = '{RATE_MAX, RATE_MAX, 1'b1};
        end else begin
            rates = '{scaled_rate(sum_sent, sum_time),
                      scaled_rate(sum_received, sum_time), 1'b0};
        end
    endtask

    task automatic offer_tick(input logic [DATA_W-1:0] sent,
                              input logic [DATA_W-1:0] received,
                              input logic [TICK_W-1:0] tick,
                              input tick_note_t        note);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        tick_notes = {tick_notes, note};
        s_valid          <= 1'b1;
        s_total_sent     <= sent;
        s_total_received <= received;
        s_tick_time_us   <= tick;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == 2 && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : scoreboard
        rate_t      predicted;
        rate_t      oldest;
        tick_note_t note;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rates.size() == 0) begin
                    $display("%0t: unexpected result beat %h %h %b",
                             $time, m_sent_rate, m_received_rate, m_no_time);
                    error_count++;
                end else begin
                    oldest = expected_rates.pop_front();
                    if (m_sent_rate !== oldest.sent_rate) begin
                        $display("%0t: sent_rate expected %h actual %h",
                                 $time, oldest.sent_rate, m_sent_rate);
                        error_count++;
                    end
                    if (m_received_rate !== oldest.received_rate) begin
                        $display("%0t: received_rate expected %h actual %h",
                                 $time, oldest.received_rate, m_received_rate);
                        error_count++;
                    end
                    if (m_no_time !== oldest.no_time) begin
                        $display("%0t: no_time expected %b actual %b",
                                 $time, oldest.no_time, m_no_time);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                note = tick_notes.pop_front();
                advance_window(s_total_sent, s_total_received, s_tick_time_us, predicted);
                if (note.typed) begin
                    predicted = note.want;
                end
                expected_rates = {expected_rates, predicted};
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [DATA_W-1:0] cur_sent;
        logic [DATA_W-1:0] cur_received;
        logic [TICK_W-1:0] tick;
        int                zero_left;
        int                roll;
        cur_sent     = '0;
        cur_received = '0;
        zero_left    = 0;
        reset_window();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 1; k <= DIRECTED[r].reps; k++) begin
                offer_tick(DIRECTED[r].sent, DIRECTED[r].received, DIRECTED[r].tick,
                           (k == DIRECTED[r].reps) ? DIRECTED[r].note : tick_note_t'(0));
            end
            cur_sent     = DIRECTED[r].sent;
            cur_received = DIRECTED[r].received;
        end

        for (int i = 0; i < RANDOM_TICKS; i++) begin
            if (i * 3 / RANDOM_TICKS != phase) begin
                phase <= i * 3 / RANDOM_TICKS;
                if (i * 3 / RANDOM_TICKS == 1) begin
                    send_idle_pct = 55;
                    recv_idle_pct <= 12;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            end

            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                cur_sent = $urandom;
            end else if (roll == 1) begin
                cur_sent = cur_sent + $urandom;
            end else begin
                cur_sent = cur_sent + $urandom_range(0, 20000);
            end
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                cur_received = $urandom;
            end else if (roll == 1) begin
                cur_received = cur_received + $urandom;
            end else begin
                cur_received = cur_received + $urandom_range(0, 20000);
            end

            roll = $urandom_range(0, 39);
            if (zero_left > 0) begin
                tick = '0;
                zero_left--;
            end else if (roll == 0) begin
                tick      = '0;
                zero_left = $urandom_range(15, 17);
            end else if (roll <= 2) begin
                tick = '0;
            end else if (roll <= 4) begin
                tick = '1;
            end else if (roll <= 9) begin
                tick = TICK_W'($urandom_range(1, 64));
            end else if (roll <= 14) begin
                tick = TICK_W'($urandom);
            end else begin
                tick = TICK_W'($urandom_range(1000, 100000));
            end

            offer_tick(cur_sent, cur_received, tick, tick_note_t'(0));
        end
        s_valid <= 1'b0;

        while (expected_rates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
